[hw/rtl/gtrm_pkg.sv]
// Shared types, constants and codes of the grid ray traversal marker.
package gtrm_pkg;

   localparam int MAP_CELLS_DEFAULT = 65536;
   localparam int MAX_MARKS_DEFAULT = 64;

   localparam logic [7:0]  OCCUPIED_VALUE = 8'd100;
   localparam logic [7:0]  SPECIAL_VALUE  = 8'd125;
   localparam logic [23:0] DELTA_MAX      = 24'hFFFFFF;

   localparam logic [8:0] COLUMNS_RESET = 9'd256;
   localparam logic [8:0] ROWS_RESET    = 9'd256;
   localparam logic [7:0] RANGE_RESET   = 8'd140;

   typedef enum logic [1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_RANGE   = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      MARK_NONE    = 2'd0,
      MARK_VISITED = 2'd1,
      MARK_SPECIAL = 2'd2
   } mark_code_type;

   typedef enum logic [2:0] {
      STOP_RANGE    = 3'd0,
      STOP_OCCUPIED = 3'd1,
      STOP_LEFT     = 3'd2,
      STOP_CAP      = 3'd3,
      STOP_WRITE    = 3'd4
   } stop_reason_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVC_GO,
      ST_DIVC_WAIT,
      ST_DIVR_GO,
      ST_DIVR_WAIT,
      ST_STEP,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        cell_address;
      logic signed [7:0]  cell_value;
      logic [7:0]         origin_col;
      logic [7:0]         origin_row;
      logic signed [15:0] dir_col;
      logic signed [15:0] dir_row;
   } req_type;

   typedef struct packed {
      logic [15:0] marked_address;
      logic [1:0]  mark_code;
      logic [2:0]  stop_reason;
      logic        last;
   } rsp_type;

endpackage

[hw/rtl/gtrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gtrm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gtrm_recip.sv]
// Bit-serial restoring divider giving the saturated Q8.16 step 2^30/mag.
module gtrm_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] mag,
   output logic        done,
   output logic [23:0] delta
);
   import gtrm_pkg::*;

   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [30:0] quo_ff, quo_in;
   logic [15:0] mag_ff, mag_in;
   logic [16:0] rem_sh;
   logic        fits;

   always_comb begin
      // the dividend is a single one at bit 30
      rem_sh = {rem_ff, (cnt_ff == 5'd30)};
      fits   = rem_sh >= {1'b0, mag_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mag_in    = mag_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 5'd30;
         rem_in    = '0;
         quo_in    = '0;
         mag_in    = mag;
      end else if (active_ff) begin
         rem_in = fits ? 16'(rem_sh - {1'b0, mag_ff}) : rem_sh[15:0];
         quo_in = {quo_ff[29:0], fits};
         if (cnt_ff == 5'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mag_ff <= mag_in;
   end

   assign done  = done_ff;
   // a zero divisor yields all ones and saturates as well
   assign delta = (quo_ff[30:24] != 7'd0) ? DELTA_MAX : quo_ff[23:0];

endmodule

[hw/rtl/grid_ray_traversal_marker_core.sv]
// Top level of the grid ray traversal marker: sequencer, map store and result port.
//
// Usage. A request is taken when start is high and busy is low. A map write
// (opcode 0) stores one byte and is acknowledged by a single result in the
// next cycle; busy stays low, so writes may follow back to back. A cast
// (opcode 1) raises busy; the shared serial divider forms the step for the
// column axis and then for the row axis, after which each cell read passes
// through ST_STEP, for bounds, range and the map address multiply, and
// ST_EVAL, for the registered map read. The final result of a cast is sent
// from ST_FINISH, and busy is low again in the cycle in which it is on rsp,
// in time for the next transfer.
// Each mark is held one cell so that the final one carries the stop reason;
// each result is on rsp for one cycle with rsp_valid high and must be taken
// then, as the receiver cannot stall. Zero direction returns at once.
// The csr channel is always ready and should be written while idle.
// Reset (synchronous) returns the sequencer to idle and the registers to
// 256 columns, 256 rows and a range of 140 cells; the map is not cleared.
module grid_ray_traversal_marker_core #(
   parameter int MAP_CELLS = gtrm_pkg::MAP_CELLS_DEFAULT,
   parameter int MAX_MARKS = gtrm_pkg::MAX_MARKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gtrm_pkg::req_type req,
   output logic              rsp_valid,
   output gtrm_pkg::rsp_type rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_data
);
   import gtrm_pkg::*;

   localparam int AW = $clog2(MAP_CELLS);
   localparam int CW = $clog2(MAX_MARKS + 1);

   state_type   state_ff, state_in;
   logic [8:0]  cols_ff, rows_ff;
   logic [7:0]  range_ff;

   logic signed [9:0] col_ff, col_in, row_ff, row_in;
   logic signed [1:0] sc_ff, sc_in, sr_ff, sr_in;
   logic        ac_ff, ac_in, ar_ff, ar_in;
   logic [15:0] magr_ff, magr_in;
   logic [31:0] tc_ff, tc_in, tr_ff, tr_in;
   logic [23:0] dtc_ff, dtc_in, dtr_ff, dtr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] idx_ff, idx_in;
   logic        pend_ff, pend_in;
   logic [15:0] pend_addr_ff, pend_addr_in;
   logic [1:0]  pend_code_ff, pend_code_in;
   logic [2:0]  reason_ff, reason_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        div_start, div_done;
   logic [15:0] div_mag, magc;
   logic [23:0] div_delta;

   logic        ram_we;
   logic [20:0] wr_wide, idx_wide;
   logic [17:0] prod;
   logic [31:0] limit;
   logic [7:0]  rd_data;
   logic        out_range, out_grid;

   gtrm_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (div_mag),
      .done  (div_done),
      .delta (div_delta)
   );

   gtrm_ram #(
      .WIDTH (8),
      .DEPTH (MAP_CELLS),
      .ADDR_W(AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_wide[AW-1:0]),
      .wr_data(req.cell_value),
      .rd_addr(idx_wide[AW-1:0]),
      .rd_data(rd_data)
   );

   assign wr_wide  = {5'd0, req.cell_address};
   assign ram_we   = start && !busy && (req.opcode == OP_WRITE) &&
                     (wr_wide < 21'(MAP_CELLS));
   assign prod     = row_ff[8:0] * cols_ff;
   assign idx_wide = 21'(prod) + 21'(col_ff[8:0]);
   assign limit    = {8'd0, range_ff, 16'd0};
   assign magc     = req.dir_col[15] ? 16'(-req.dir_col) : req.dir_col;
   assign out_range = (ac_ff && tc_ff >= limit) || (ar_ff && tr_ff >= limit);
   assign out_grid  = col_ff[9] || row_ff[9] || ({1'b0, col_ff[8:0]} >= {1'b0, cols_ff}) ||
                      ({1'b0, row_ff[8:0]} >= {1'b0, rows_ff}) ||
                      (idx_wide >= 21'(MAP_CELLS));

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sc_in        = sc_ff;
      sr_in        = sr_ff;
      ac_in        = ac_ff;
      ar_in        = ar_ff;
      magr_in      = magr_ff;
      tc_in        = tc_ff;
      tr_in        = tr_ff;
      dtc_in       = dtc_ff;
      dtr_in       = dtr_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_code_in = pend_code_ff;
      reason_in    = reason_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_mag      = magc;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.opcode == OP_WRITE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{req.cell_address, MARK_NONE, STOP_WRITE, 1'b1};
               end else if (req.dir_col == 16'sd0 && req.dir_row == 16'sd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{16'd0, MARK_NONE, STOP_RANGE, 1'b1};
               end else begin
                  col_in  = {2'b00, req.origin_col};
                  row_in  = {2'b00, req.origin_row};
                  ac_in   = req.dir_col != 16'sd0;
                  ar_in   = req.dir_row != 16'sd0;
                  sc_in   = req.dir_col[15] ? -2'sd1 : 2'sd1;
                  sr_in   = req.dir_row[15] ? -2'sd1 : 2'sd1;
                  magr_in = req.dir_row[15] ? 16'(-req.dir_row) : req.dir_row;
                  tc_in   = '0;
                  tr_in   = '0;
                  cnt_in  = '0;
                  pend_in = 1'b0;
                  div_start = 1'b1;
                  state_in  = ST_DIVC_WAIT;
               end
            end
         end
         ST_DIVC_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVC_WAIT;
         end
         ST_DIVC_WAIT: begin
            if (div_done) begin
               dtc_in   = div_delta;
               state_in = ST_DIVR_GO;
            end
         end
         ST_DIVR_GO: begin
            div_start = 1'b1;
            div_mag   = magr_ff;
            state_in  = ST_DIVR_WAIT;
         end
         ST_DIVR_WAIT: begin
            if (div_done) begin
               dtr_in   = div_delta;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // range first, then bounds; the map read is issued here
            if (out_range) begin
               reason_in = STOP_RANGE;
               state_in  = ST_FINISH;
            end else if (out_grid) begin
               reason_in = STOP_LEFT;
               state_in  = ST_FINISH;
            end else begin
               idx_in   = idx_wide[15:0];
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rd_data == OCCUPIED_VALUE) begin
               reason_in = STOP_OCCUPIED;
               state_in  = ST_FINISH;
            end else begin
               // release the held mark, hold the new one
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{pend_addr_ff, pend_code_ff, STOP_RANGE, 1'b0};
               end
               pend_in      = 1'b1;
               pend_addr_in = idx_ff;
               pend_code_in = (rd_data == SPECIAL_VALUE) ? MARK_SPECIAL : MARK_VISITED;
               cnt_in       = cnt_ff + CW'(1);
               if ({1'b0, cnt_ff} + (CW+1)'(1) >= (CW+1)'(MAX_MARKS)) begin
                  reason_in = STOP_CAP;
                  state_in  = ST_FINISH;
               end else begin
                  if (ac_ff && (!ar_ff || tc_ff < tr_ff)) begin
                     tc_in  = tc_ff + 32'(dtc_ff);
                     col_in = col_ff + 10'(sc_ff);
                  end else begin
                     tr_in  = tr_ff + 32'(dtr_ff);
                     row_in = row_ff + 10'(sr_ff);
                  end
                  state_in = ST_STEP;
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (pend_ff) begin
               rsp_in = '{pend_addr_ff, pend_code_ff, reason_ff, 1'b1};
            end else begin
               rsp_in = '{16'd0, MARK_NONE, reason_ff, 1'b1};
            end
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cols_ff      <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         range_ff     <= RANGE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_COLUMNS: cols_ff  <= csr_data;
               CSR_ROWS:    rows_ff  <= csr_data;
               CSR_RANGE:   range_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
      col_ff       <= col_in;
      row_ff       <= row_in;
      sc_ff        <= sc_in;
      sr_ff        <= sr_in;
      ac_ff        <= ac_in;
      ar_ff        <= ar_in;
      magr_ff      <= magr_in;
      tc_ff        <= tc_in;
      tr_ff        <= tr_in;
      dtc_ff       <= dtc_in;
      dtr_ff       <= dtr_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      pend_code_ff <= pend_code_in;
      reason_ff    <= reason_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign csr_ready = 1'b1;

   a_end_with_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp.last)
      else $error("cast ended without a final result");

   a_inner_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last |-> busy)
      else $error("non-final result outside a cast");

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.opcode == OP_WRITE |=>
         rsp_valid && rsp.last && rsp.stop_reason == STOP_WRITE)
      else $error("write transfer not acknowledged");

endmodule

[tb/grid_ray_traversal_marker_core_checker.sv]
// Checker for the grid ray traversal marker: predicts marks and compares results.
`timescale 1ns / 100ps

module grid_ray_traversal_marker_core_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  gtrm_pkg::req_type req,
   input  logic              rsp_valid,
   input  gtrm_pkg::rsp_type rsp,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_data,
   output int                error_count,
   output int                outstanding,
   output int                result_count
);
   import gtrm_pkg::*;

   localparam int MAP_SIZE = MAP_CELLS_DEFAULT;
   localparam int MARK_CAP = MAX_MARKS_DEFAULT;

   logic [7:0] cell_shadow [0:MAP_SIZE-1];
   logic [8:0] columns_reg;
   logic [8:0] rows_reg;
   logic [7:0] range_reg;
   rsp_type    mark_queue [$];

   function automatic logic [31:0] axis_delta(input int d);
      int unsigned mag;
      int unsigned q;
      mag = (d < 0) ? -d : d;
      if (mag == 0) return 32'(DELTA_MAX);
      q = (32'd1 << 30) / mag;
      return (q > 32'(DELTA_MAX)) ? 32'(DELTA_MAX) : q;
   endfunction

   // Amanatides-Woo walk from the corner of the origin cell.
   function automatic void predict_walk(input req_type r);
      int              col, row, dc, dr, sc, sr;
      bit              ac, ar;
      logic [31:0]     tc, tr, dtc, dtr, bound;
      longint          idx;
      logic [7:0]      v;
      stop_reason_type why;
      rsp_type         walk [$];
      rsp_type         m;
      col = int'(r.origin_col);
      row = int'(r.origin_row);
      dc  = int'($signed(r.dir_col));
      dr  = int'($signed(r.dir_row));
      if (dc == 0 && dr == 0) begin
         m = '{16'd0, MARK_NONE, STOP_RANGE, 1'b1};
         mark_queue = {mark_queue, m};
         return;
      end
      ac    = (dc != 0);
      ar    = (dr != 0);
      sc    = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
      sr    = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
      dtc   = axis_delta(dc);
      dtr   = axis_delta(dr);
      tc    = '0;
      tr    = '0;
      bound = 32'(range_reg) << 16;
      why   = STOP_RANGE;
      forever begin
         if ((ac && tc >= bound) || (ar && tr >= bound)) begin
            why = STOP_RANGE;
            break;
         end
         if (col < 0 || col >= int'(columns_reg) || row < 0 || row >= int'(rows_reg)) begin
            why = STOP_LEFT;
            break;
         end
         idx = longint'(row) * longint'(columns_reg) + longint'(col);
         if (idx >= MAP_SIZE) begin
            why = STOP_LEFT;
            break;
         end
         v = cell_shadow[idx];
         if (v == OCCUPIED_VALUE) begin
            why = STOP_OCCUPIED;
            break;
         end
         m.marked_address = 16'(idx);
         m.mark_code      = (v == SPECIAL_VALUE) ? MARK_SPECIAL : MARK_VISITED;
         m.stop_reason    = STOP_RANGE;
         m.last           = 1'b0;
         walk = {walk, m};
         if (walk.size() >= MARK_CAP) begin
            why = STOP_CAP;
            break;
         end
         if (ac && (!ar || tc < tr)) begin
            tc  = tc + dtc;
            col = col + sc;
         end else begin
            tr  = tr + dtr;
            row = row + sr;
         end
      end
      if (walk.size() == 0) begin
         m = '{16'd0, MARK_NONE, why, 1'b1};
         walk = {walk, m};
      end else begin
         walk[walk.size()-1].stop_reason = why;
         walk[walk.size()-1].last        = 1'b1;
      end
      mark_queue = {mark_queue, walk};
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type ack;
      if (reset) begin
         columns_reg <= COLUMNS_RESET;
         rows_reg    <= ROWS_RESET;
         range_reg   <= RANGE_RESET;
         error_count  = 0;
         result_count = 0;
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (mark_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result addr=%h code=%0d reason=%0d last=%0d",
                           $realtime, rsp.marked_address, rsp.mark_code,
                           rsp.stop_reason, rsp.last);
            end else begin
               want = mark_queue.pop_front();
               if (rsp.marked_address !== want.marked_address ||
                   rsp.mark_code !== want.mark_code ||
                   rsp.stop_reason !== want.stop_reason || rsp.last !== want.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                              $realtime, want.marked_address, want.mark_code,
                              want.stop_reason, want.last, rsp.marked_address,
                              rsp.mark_code, rsp.stop_reason, rsp.last);
               end
            end
         end
         if (start && !busy) begin
            if (req.opcode == OP_WRITE) begin
               cell_shadow[req.cell_address] = req.cell_value;
               ack = '{req.cell_address, MARK_NONE, STOP_WRITE, 1'b1};
               mark_queue = {mark_queue, ack};
            end else begin
               predict_walk(req);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMNS: columns_reg <= csr_data;
               CSR_ROWS:    rows_reg    <= csr_data;
               CSR_RANGE:   range_reg   <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      outstanding <= mark_queue.size();
   end

endmodule

[tb/grid_ray_traversal_marker_core_test.sv]
// Stimulus and verdict for the grid ray traversal marker.
`timescale 1ns / 100ps

module grid_ray_traversal_marker_core_test;
   import gtrm_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // every geometry of the random phases keeps columns*rows within these loaded cells
   localparam int LOAD_CELLS = 64;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req;
   logic       rsp_valid;
   rsp_type    rsp;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [8:0] csr_data;
   int         error_count, outstanding, result_count;
   int         idle_pct;
   int         sent, casts;
   int         cur_columns, cur_rows;

   grid_ray_traversal_marker_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   grid_ray_traversal_marker_core_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .error_count(error_count),
      .outstanding(outstanding), .result_count(result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[grid_ray_traversal_marker_core] ERROR");
      $finish;
   end

   // Hold start high across back-to-back transfers; drop it only to idle.
   task automatic send(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      sent++;
      if (r.opcode == OP_CAST) casts++;
   endtask

   task automatic write_cell(input logic [15:0] a, input logic [7:0] v);
      req_type r;
      r = '0;
      r.opcode       = OP_WRITE;
      r.cell_address = a;
      r.cell_value   = v;
      send(r);
   endtask

   task automatic cast_ray(input logic [7:0] c, input logic [7:0] rw,
                           input logic [15:0] dc, input logic [15:0] dr);
      req_type r;
      r = '0;
      r.opcode     = OP_CAST;
      r.origin_col = c;
      r.origin_row = rw;
      r.dir_col    = dc;
      r.dir_row    = dr;
      send(r);
   endtask

   task automatic settle();
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (outstanding == 0 && !busy) break;
      end
      repeat (8) @(posedge clock);
   endtask

   // Leave valid high; the caller drops it after the last transfer.
   task automatic write_csr(input logic [1:0] idx, input logic [8:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [8:0] c, input logic [8:0] rw,
                           input logic [8:0] rng);
      settle();
      write_csr(CSR_COLUMNS, c);
      write_csr(CSR_ROWS, rw);
      write_csr(CSR_RANGE, rng);
      write_csr(CSR_UNUSED, 9'($urandom));
      csr_valid <= 1'b0;
      cur_columns = int'(c);
      cur_rows    = int'(rw);
   endtask

   function automatic logic [7:0] map_byte();
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) return OCCUPIED_VALUE;
      if (p < 13) return SPECIAL_VALUE;
      return 8'($urandom);
   endfunction

   task automatic random_item();
      int          p, span;
      logic [7:0]  c, rw;
      logic [15:0] dc, dr;
      if ($urandom_range(0, 99) < 35) begin
         span = cur_columns * cur_rows;
         if (span < 1) span = 1;
         if (span > 65536) span = 65536;
         p = $urandom_range(0, 99);
         write_cell((p < 75) ? 16'($urandom_range(0, span - 1)) : 16'($urandom),
                    (p % 10 == 0) ? OCCUPIED_VALUE : map_byte());
      end else begin
         if ($urandom_range(0, 9) == 0 || cur_columns < 1 || cur_rows < 1) begin
            c  = 8'($urandom);
            rw = 8'($urandom);
         end else begin
            c  = 8'($urandom_range(0, (cur_columns > 256 ? 256 : cur_columns) - 1));
            rw = 8'($urandom_range(0, (cur_rows > 256 ? 256 : cur_rows) - 1));
         end
         p = $urandom_range(0, 99);
         if (p < 60) begin
            dc = 16'(int'($urandom_range(0, 32768)) - 16384);
            dr = 16'(int'($urandom_range(0, 32768)) - 16384);
         end else if (p < 75) begin
            dc = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 32768)) - 16384) : 16'd0;
            dr = (dc == 0) ? 16'(int'($urandom_range(0, 32768)) - 16384) : 16'd0;
         end else if (p < 80) begin
            dc = '0;
            dr = '0;
         end else begin
            dc = 16'($urandom);
            dr = 16'($urandom);
         end
         cast_ray(c, rw, dc, dr);
      end
   endtask

   initial begin
      logic [8:0] setting [8][3];
      start     = 1'b0;
      req       = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COLUMNS;
      csr_data  = '0;
      reset     = 1'b1;
      idle_pct  = 0;
      sent      = 0;
      casts     = 0;
      cur_columns = 256;
      cur_rows    = 256;
      setting = '{'{9'd8, 9'd8, 9'd140}, '{9'd1, 9'd1, 9'd1},
                  '{9'd0, 9'd5, 9'd255}, '{9'd511, 9'd0, 9'd255},
                  '{9'd64, 9'd1, 9'd20}, '{9'd1, 9'd64, 9'd256},
                  '{9'd7, 9'd9, 9'd90}, '{9'd16, 9'd4, 9'd3}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: these walks touch written cells only.
      write_cell(16'd0, 8'h80);
      write_cell(16'd1, SPECIAL_VALUE);
      write_cell(16'd2, OCCUPIED_VALUE);
      write_cell(16'hFFFF, 8'h7F);
      cast_ray(8'd0, 8'd0, 16'sd16384, 16'sd0);
      cast_ray(8'd0, 8'd0, 16'sd0, 16'sd0);
      cast_ray(8'd255, 8'd255, 16'sd16384, 16'sd16384);
      cast_ray(8'd255, 8'd255, 16'sd16384, 16'sd0);

      // Load the small map that every later walk stays within.
      set_grid(9'd8, 9'd8, 9'd140);
      for (int a = 0; a < LOAD_CELLS; a++) write_cell(16'(a), map_byte());
      write_cell(16'd12, OCCUPIED_VALUE);
      cast_ray(8'd0, 8'd0, 16'sd16384, 16'sd0);
      cast_ray(8'd7, 8'd7, -16'sd16384, -16'sd16384);
      cast_ray(8'd0, 8'd0, 16'sd0, 16'sd16384);
      cast_ray(8'd3, 8'd3, 16'h8000, 16'h7FFF);
      cast_ray(8'd4, 8'd4, 16'sd1, -16'sd1);
      cast_ray(8'd2, 8'd5, 16'sd11585, 16'sd11585);
      cast_ray(8'd7, 8'd0, -16'sd16384, 16'sd0);
      cast_ray(8'd6, 8'd1, -16'sd5000, 16'sd15600);

      // A start cell in bounds whose address is past the store.
      set_grid(9'd511, 9'd256, 9'd255);
      cast_ray(8'd0, 8'd200, 16'sd0, 16'sd16384);

      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph < 3) ? 29 : ((ph < 6) ? 68 : 0);
         set_grid(setting[ph][0], setting[ph][1], setting[ph][2]);
         for (int k = 0; k < 15; k++) random_item();
      end

      settle();
      $display("Covered %0d requests (%0d casts) over 10 register settings,",
               sent, casts);
      $display("%0d results checked.", result_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("[grid_ray_traversal_marker_core] OK");
      end else begin
         $display("[grid_ray_traversal_marker_core] ERROR");
      end
      $finish;
   end

endmodule
